/* hdl/skmer_pkg.sv */
package skmer_pkg;

  // Configuration register indexes.
  localparam int unsigned IDX_W = 2;
  typedef logic [IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_KMER_LEN = 2'd0;
  localparam cfg_idx_t REG_MMER_LEN = 2'd1;

  // Register widths and reset values.
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned KLEN_W     = 5;
  localparam int unsigned MLEN_W     = 4;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [KLEN_W-1:0]     klen_t;
  typedef logic [MLEN_W-1:0]     mlen_t;
  localparam klen_t KMER_LEN_RESET = 5'd25;
  localparam mlen_t MMER_LEN_RESET = 4'd8;

  // Character that breaks the window.
  typedef logic [7:0] char_t;
  localparam char_t N_CHAR = 8'h4E;

  // Leaves of the minimum tree; covers every legal k-mer length.
  localparam int unsigned TREE_LEAVES = 32;

endpackage

/* hdl/superkmer_minimizer_splitter.sv */
// Superkmer splitter with minimizer search.
//
// Input channel (in_valid/in_ready) carries one read character per request,
// with last_of_read on the final character of a read. Output channel
// (out_valid/out_ready) gives one result per input request: the k-mer valid
// flag, canonical k-mer, minimizer, superkmer start flag and the read_done
// echo. Fields other than read_done are zero when no full k-mer is present.
//
// Throughput is one request per cycle while out_ready stays high. The path is a five-register
// pipeline: window update, canonical k-mer and per-position canonical m-mers, two
// registered levels of the 32-leaf minimum tree, and the output register
// where the superkmer start is decided.
//
// Each stage advances when its successor has room, so a stalled receiver
// fills the pipeline and then drops in_ready; bubbles are squeezed out.
// Reset clears the pipeline, the windows and the configuration to k=25, m=8.
// Configuration writes (cfg_we) to the length registers take effect at once and clear the windows;
// the user must issue them only while the pipeline is empty, as the block does not enforce this.
module superkmer_minimizer_splitter #(
  parameter int MAX_KMER_LEN = 31,
  parameter int MAX_MMER_LEN = 15
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  skmer_pkg::cfg_idx_t         cfg_index,
  input  skmer_pkg::cfg_data_t        cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  skmer_pkg::char_t            base_char,
  input  logic                        last_of_read,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        kmer_valid,
  output logic [2*MAX_KMER_LEN-1:0]   canonical_kmer,
  output logic [2*MAX_MMER_LEN-1:0]   minimizer,
  output logic                        starts_superkmer,
  output logic                        read_done
);
  import skmer_pkg::*;

  localparam int KW = 2 * MAX_KMER_LEN;
  localparam int MW = 2 * MAX_MMER_LEN;
  localparam int CW = $clog2(MAX_KMER_LEN + 1);
  localparam int SW = $clog2(KW + 1) + 1;
  localparam klen_t KMAX = klen_t'(MAX_KMER_LEN);
  localparam mlen_t MMAX = mlen_t'(MAX_MMER_LEN);
  localparam int L3 = TREE_LEAVES / 4;
  localparam int L4 = L3 / 4;

  function automatic logic [MW-1:0] min2(input logic [MW-1:0] a, input logic [MW-1:0] b);
    min2 = (b < a) ? b : a;
  endfunction

  // Configuration registers.
  klen_t kmer_len;
  mlen_t mmer_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len <= KMER_LEN_RESET;
      mmer_len <= MMER_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KMER_LEN: kmer_len <= cfg_data[KLEN_W-1:0];
        REG_MMER_LEN: mmer_len <= cfg_data[MLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective lengths after clamping.
  klen_t k_eff;
  mlen_t m_eff;

  always_comb begin
    if (kmer_len == '0) begin
      k_eff = klen_t'(1);
    end else if (kmer_len > KMAX) begin
      k_eff = KMAX;
    end else begin
      k_eff = kmer_len;
    end
    if (mmer_len == '0) begin
      m_eff = mlen_t'(1);
    end else if (mmer_len > MMAX) begin
      m_eff = MMAX;
    end else begin
      m_eff = mmer_len;
    end
    if ({1'b0, m_eff} > k_eff) begin
      m_eff = k_eff[MLEN_W-1:0];
    end
  end

  logic cfg_hit;
  assign cfg_hit = cfg_we && (cfg_index == REG_KMER_LEN || cfg_index == REG_MMER_LEN);

  // Pipeline control: each stage loads when its successor has room.
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  assign rdy5 = !v5 || out_ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  logic accept;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // Rolling window state.
  logic [KW-1:0] fwd, rev;
  logic [CW-1:0] cnt;
  logic          open;

  logic [KW-1:0] kmask, fwd_next, rev_next, ins;
  logic [CW-1:0] cnt_next;
  logic [1:0]    base;
  logic          is_n, kv_next, first_next, open_next;

  always_comb begin
    kmask      = ~({KW{1'b1}} << {k_eff, 1'b0});
    base       = base_char[2:1];
    is_n       = (base_char == N_CHAR);
    ins        = {{(KW-2){1'b0}}, base ^ 2'b10} << ({k_eff, 1'b0} - 6'd2);
    fwd_next   = ((fwd << 2) | {{(KW-2){1'b0}}, base}) & kmask;
    rev_next   = ((rev >> 2) | ins) & kmask;
    cnt_next   = (CW'(cnt) < CW'(k_eff)) ? cnt + CW'(1) : cnt;
    kv_next    = !is_n && (cnt_next >= CW'(k_eff));
    first_next = kv_next && !open;
    open_next  = open || kv_next;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      fwd  <= '0;
      rev  <= '0;
      cnt  <= '0;
      open <= 1'b0;
    end else if (accept) begin
      if (is_n || last_of_read) begin
        fwd  <= '0;
        rev  <= '0;
        cnt  <= '0;
        open <= 1'b0;
      end else begin
        fwd  <= fwd_next;
        rev  <= rev_next;
        cnt  <= cnt_next;
        open <= open_next;
      end
    end
  end

  // Stage 1: updated windows.
  logic [KW-1:0] s1_fwd, s1_rev;
  logic          s1_kv, s1_first, s1_last;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_fwd   <= fwd_next;
      s1_rev   <= rev_next;
      s1_kv    <= kv_next;
      s1_first <= first_next;
      s1_last  <= last_of_read;
    end
  end

  // Canonical m-mer at every base position of the forward k-mer.
  logic [KW+MW-1:0] fwd_ext;
  logic [MW-1:0]    mmask;
  assign fwd_ext = {{MW{1'b0}}, s1_fwd};
  assign mmask   = ~({MW{1'b1}} << {m_eff, 1'b0});

  logic [MW-1:0] leaf [TREE_LEAVES];

  for (genvar i = 0; i < TREE_LEAVES; i++) begin : g_leaf
    if (i < MAX_KMER_LEN) begin : g_pos
      logic [KW+MW-1:0] shifted;
      logic [MW-1:0]    x, rfull, r;
      logic             pos_ok;
      always_comb begin
        shifted = fwd_ext >> (2 * i);
        x       = shifted[MW-1:0] & mmask;
        for (int j = 0; j < MAX_MMER_LEN; j++) begin
          rfull[2*(MAX_MMER_LEN-1-j) +: 2] = x[2*j +: 2] ^ 2'b10;
        end
        r       = rfull >> (MW - 2 * int'(m_eff));
        pos_ok  = (SW'(i) + SW'(m_eff)) <= SW'(k_eff);
        leaf[i] = pos_ok ? ((r < x) ? r : x) : mmask;
      end
    end else begin : g_pad
      assign leaf[i] = '1;
    end
  end

  // Stage 2: canonical k-mer and tree leaves.
  logic [KW-1:0] s2_canon;
  logic [MW-1:0] s2_leaf [TREE_LEAVES];
  logic          s2_kv, s2_first, s2_last;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_canon <= (s1_rev < s1_fwd) ? s1_rev : s1_fwd;
      s2_leaf  <= leaf;
      s2_kv    <= s1_kv;
      s2_first <= s1_first;
      s2_last  <= s1_last;
    end
  end

  // Stage 3: two tree levels, four leaves to one.
  logic [KW-1:0] s3_canon;
  logic [MW-1:0] s3_min [L3];
  logic          s3_kv, s3_first, s3_last;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int g = 0; g < L3; g++) begin
        s3_min[g] <= min2(min2(s2_leaf[4*g], s2_leaf[4*g+1]),
                          min2(s2_leaf[4*g+2], s2_leaf[4*g+3]));
      end
      s3_canon <= s2_canon;
      s3_kv    <= s2_kv;
      s3_first <= s2_first;
      s3_last  <= s2_last;
    end
  end

  // Stage 4: two more tree levels.
  logic [KW-1:0] s4_canon;
  logic [MW-1:0] s4_min [L4];
  logic          s4_kv, s4_first, s4_last;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int g = 0; g < L4; g++) begin
        s4_min[g] <= min2(min2(s3_min[4*g], s3_min[4*g+1]),
                          min2(s3_min[4*g+2], s3_min[4*g+3]));
      end
      s4_canon <= s3_canon;
      s4_kv    <= s3_kv;
      s4_first <= s3_first;
      s4_last  <= s3_last;
    end
  end

  // Output stage: final minimum and superkmer boundary.
  logic [MW-1:0] mini, prev_min;
  logic          new_sk;
  assign mini   = min2(s4_min[0], s4_min[1]);
  assign new_sk = s4_first || (mini != prev_min);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_min <= '0;
    end else if (rdy5 && v4 && s4_kv) begin
      prev_min <= mini;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      kmer_valid       <= s4_kv;
      canonical_kmer   <= s4_kv ? s4_canon : '0;
      minimizer        <= s4_kv ? mini : '0;
      starts_superkmer <= s4_kv && new_sk;
      read_done        <= s4_last;
    end
  end

  assign out_valid = v5;

  // Checks on the block's own logic.
  a_no_kmer_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kmer_valid |-> canonical_kmer == '0 && minimizer == '0 && !starts_superkmer)
    else $error("fields not zero without a k-mer");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    !cfg_we |-> CW'(cnt) <= CW'(k_eff))
    else $error("base count above k-mer length");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> cnt == '0 && !open)
    else $error("register write did not clear the window");

  a_first_kmer_starts: assert property (@(posedge clk) disable iff (rst)
    rdy5 && v4 && s4_kv && s4_first |=> starts_superkmer)
    else $error("first k-mer did not open a superkmer");

endmodule

/* tb/sv/superkmer_minimizer_splitter_test.sv */
`timescale 1ns / 100ps

module superkmer_minimizer_splitter_test;
  import skmer_pkg::*;

  localparam int KMER_BITS = 62;
  localparam int MMER_BITS = 30;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 16;
  localparam int TIMEOUT_NS = 2_000_000;

  // Register indexes that map to nothing in the block.
  localparam cfg_idx_t IDX_SPARE_A = 2'd2;
  localparam cfg_idx_t IDX_SPARE_B = 2'd3;

  typedef struct packed {
    char_t ch;
    logic  is_last;
  } char_req_t;

  typedef struct packed {
    logic                 valid;
    logic [KMER_BITS-1:0] canon;
    logic [MMER_BITS-1:0] mini;
    logic                 starts;
    logic                 done;
  } kmer_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = '0;
  cfg_data_t cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  char_t base_char = '0;
  logic last_of_read = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kmer_valid;
  logic [KMER_BITS-1:0] canonical_kmer;
  logic [MMER_BITS-1:0] minimizer;
  logic starts_superkmer;
  logic read_done;

  superkmer_minimizer_splitter u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .base_char(base_char),
    .last_of_read(last_of_read),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kmer_valid(kmer_valid),
    .canonical_kmer(canonical_kmer),
    .minimizer(minimizer),
    .starts_superkmer(starts_superkmer),
    .read_done(read_done)
  );

  // Predicted block state and configuration.
  klen_t       klen_cfg = KMER_LEN_RESET;
  mlen_t       mlen_cfg = MMER_LEN_RESET;
  logic [63:0] fwd_win = '0;
  logic [63:0] rev_win = '0;
  logic [4:0]  bases_seen = '0;
  logic [63:0] prev_mini = '0;
  logic        sk_open = 1'b0;

  char_req_t    pending_chars[$];
  kmer_result_t expected_kmers[$];
  char_req_t    next_req;
  kmer_result_t want_res;
  kmer_result_t got_res;
  kmer_result_t new_res;

  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned mismatch_count = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;
  bit quiet_tail = 1'b0;
  bit in_taken = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Window state is dropped on an N, at the end of a read and on a register write.
  task automatic clear_window();
    fwd_win = '0;
    rev_win = '0;
    bases_seen = '0;
    sk_open = 1'b0;
  endtask

  // Lesser of an m-mer and its reverse complement.
  function automatic logic [63:0] canonical_mmer(input logic [63:0] x, input int unsigned m);
    logic [63:0] rc;
    rc = '0;
    for (int j = 0; j < m; j++) begin
      rc = (rc << 2) | (((x >> (2 * j)) & 64'd3) ^ 64'd2);
    end
    return (rc < x) ? rc : x;
  endfunction

  // Advance the predicted window by one character and form its result.
  task automatic predict_char(input char_t ch, input logic is_last, output kmer_result_t res);
    int unsigned k;
    int unsigned m;
    logic [63:0] kmask;
    logic [63:0] mmask;
    logic [63:0] comp;
    logic [63:0] part;
    logic [63:0] best;
    res = '0;
    k = (klen_cfg == 0) ? 1 : klen_cfg;
    m = (mlen_cfg == 0) ? 1 : mlen_cfg;
    if (m > k) m = k;
    kmask = (64'd1 << (2 * k)) - 64'd1;
    mmask = (64'd1 << (2 * m)) - 64'd1;
    if (ch == N_CHAR) begin
      clear_window();
    end else begin
      comp = {62'd0, ch[2:1] ^ 2'd2};
      fwd_win = ((fwd_win << 2) | {62'd0, ch[2:1]}) & kmask;
      rev_win = ((rev_win >> 2) | (comp << (2 * (k - 1)))) & kmask;
      if (bases_seen < k) bases_seen++;
      if (bases_seen >= k) begin
        // Scan every base position of the forward k-mer for the least m-mer.
        best = mmask;
        for (int i = 0; i + m <= k; i++) begin
          part = canonical_mmer((fwd_win >> (2 * i)) & mmask, m);
          if (part < best) best = part;
        end
        res.valid = 1'b1;
        res.canon = (fwd_win < rev_win) ? fwd_win[KMER_BITS-1:0] : rev_win[KMER_BITS-1:0];
        res.mini = best[MMER_BITS-1:0];
        res.starts = !sk_open || (best != prev_mini);
        prev_mini = best;
        sk_open = 1'b1;
      end
    end
    if (is_last) clear_window();
    res.done = is_last;
  endtask

  task automatic note_error(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // Request driver: one request per handshake, random gaps between requests.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // Request still waiting; valid and payload stay as they are.
    end else if (src_gap > 0) begin
      src_gap--;
      in_valid <= 1'b0;
    end else if (pending_chars.size() != 0) begin
      next_req = pending_chars.pop_front();
      base_char <= next_req.ch;
      last_of_read <= next_req.is_last;
      in_valid <= 1'b1;
      if (!quiet_tail && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 8);
    end else begin
      in_valid <= 1'b0;
    end
    in_taken = 1'b0;
  end

  // Receiver: random stalls, plus one long hold when asked for.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet_tail && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 8);
    end
  end

  // Predict on each accepted request, then check each accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_char(base_char, last_of_read, new_res);
        expected_kmers.insert(expected_kmers.size(), new_res);
        accepted_total++;
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        got_res = {kmer_valid, canonical_kmer, minimizer, starts_superkmer, read_done};
        if (expected_kmers.size() == 0) begin
          note_error($sformatf("result with nothing outstanding: valid=%b kmer=%h min=%h start=%b done=%b",
                               got_res.valid, got_res.canon, got_res.mini, got_res.starts,
                               got_res.done));
        end else begin
          want_res = expected_kmers.pop_front();
          if (got_res !== want_res) begin
            note_error($sformatf({"result differs: expected valid=%b kmer=%h min=%h start=%b done=%b,",
                                  " actual valid=%b kmer=%h min=%h start=%b done=%b"},
                                 want_res.valid, want_res.canon, want_res.mini, want_res.starts,
                                 want_res.done, got_res.valid, got_res.canon, got_res.mini,
                                 got_res.starts, got_res.done));
          end
        end
      end
    end
  end

  function automatic char_t base_letter(input logic [1:0] sel);
    case (sel)
      2'd0: return "A";
      2'd1: return "C";
      2'd2: return "G";
      default: return "T";
    endcase
  endfunction

  // Mostly clean bases, some lowercase, some N and some arbitrary bytes.
  function automatic char_t pick_char();
    int unsigned roll;
    logic [1:0] sel;
    char_t raw;
    roll = $urandom_range(0, 99);
    sel = 2'($urandom_range(0, 3));
    raw = char_t'($urandom_range(0, 255));
    if (roll < 82) return base_letter(sel);
    else if (roll < 90) return base_letter(sel) | 8'h20;
    else if (roll < 94) return N_CHAR;
    else return raw;
  endfunction

  task automatic push_char(input char_t ch, input logic is_last);
    char_req_t req;
    req.ch = ch;
    req.is_last = is_last;
    pending_chars.insert(pending_chars.size(), req);
    queued_total++;
  endtask

  task automatic push_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) push_char(s[i], close && (i == s.len() - 1));
  endtask

  task automatic queue_read(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_char(pick_char(), i == len - 1);
  endtask

  // Wait until every request is taken and every result is back.
  task automatic wait_idle();
    do @(negedge clk); while (accepted_total != queued_total || expected_kmers.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_KMER_LEN) begin
      klen_cfg = val[KLEN_W-1:0];
      clear_window();
    end else if (idx == REG_MMER_LEN) begin
      mlen_cfg = val[MLEN_W-1:0];
      clear_window();
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One configuration setting followed by random reads.
  task automatic run_phase(input cfg_data_t kval, input cfg_data_t mval, input int unsigned count,
                           input bit pause_mid, input bit hold_out);
    int unsigned k_eff;
    int unsigned sent;
    int unsigned len;
    bit paused;
    wait_idle();
    write_reg(REG_KMER_LEN, kval);
    write_reg(REG_MMER_LEN, mval);
    k_eff = (kval == 0) ? 1 : kval;
    sent = 0;
    paused = 1'b0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) len = $urandom_range(1, k_eff);
      else len = k_eff + $urandom_range(0, 48);
      queue_read(len);
      sent += len;
      if (pause_mid && !paused && sent >= count / 2) begin
        paused = 1'b1;
        wait_idle();
      end
    end
    if (hold_out) begin
      @(posedge clk);
      hold_request = 1'b1;
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: one read long enough for two k-mers, opening with byte extremes.
    push_char("n", 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b0);
    for (int i = 0; i < 23; i++) push_char(base_letter(i[1:0] ^ i[3:2]), i == 22);

    // Short k-mers: window fill, an N inside a read, reads with no k-mer.
    wait_idle();
    write_reg(REG_KMER_LEN, 5'd4);
    write_reg(REG_MMER_LEN, 5'd2);
    push_text("ACGTT", 1'b0);
    push_char(N_CHAR, 1'b0);
    push_text("GGGG", 1'b1);
    push_char(N_CHAR, 1'b1);
    push_char("C", 1'b1);

    // Writes to unmapped indexes leave an open read untouched.
    push_text("CA", 1'b0);
    wait_idle();
    write_reg(IDX_SPARE_A, 5'h1F);
    write_reg(IDX_SPARE_B, 5'h01);
    push_text("GTA", 1'b1);

    run_phase(5'd0, 5'd0, 120, 1'b0, 1'b0);
    run_phase(5'd31, 5'd15, 200, 1'b0, 1'b1);
    run_phase(5'd3, 5'd8, 120, 1'b1, 1'b0);
    run_phase(5'd1, 5'd15, 80, 1'b0, 1'b0);
    run_phase(5'd31, 5'd1, 150, 1'b0, 1'b0);
    // Bit 4 of the m-mer length write is ignored by the register.
    run_phase(5'd17, 5'd26, 150, 1'b0, 1'b0);
    run_phase(5'd2, 5'd1, 100, 1'b0, 1'b0);
    repeat (4) run_phase(cfg_data_t'($urandom_range(0, 31)), cfg_data_t'($urandom_range(0, 31)),
                         150, 1'b0, 1'b0);

    // Closing stretch at full rate on both sides.
    wait_idle();
    @(posedge clk);
    quiet_tail = 1'b1;
    run_phase(cfg_data_t'($urandom_range(0, 31)), cfg_data_t'($urandom_range(0, 31)),
              150, 1'b0, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("superkmer_minimizer_splitter: match");
    end else begin
      $display("superkmer_minimizer_splitter: mismatch");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("superkmer_minimizer_splitter: mismatch");
    $finish;
  end

endmodule
